>>> src/coap_nfc_header_parser_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the CoAP-over-NFC header parser
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef COAP_NFC_HEADER_PARSER_CORE_MACROS_SVH
`define COAP_NFC_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define CNHP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cnhp assertion failed");

// next-cycle implication
`define CNHP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cnhp assertion failed");

`endif

>>> src/cnhp_pkg.sv
// ---------------------------------------------------------------------------
// CoAP-over-NFC header parser package
// Preface masks, status codes and the result record layout.
// ---------------------------------------------------------------------------
package cnhp_pkg;

   localparam int unsigned MAX_TOKEN_BYTES = 8;
   localparam logic [16:0] POS_SAT         = 17'h1ffff;

   localparam logic [7:0] PF_FIXED = 8'h80;
   localparam logic [7:0] PF_RESET = 8'h40;
   localparam logic [7:0] PF_IND   = 8'h30;
   localparam logic [7:0] PF_RFU   = 8'h20;
   localparam logic [7:0] PF_MID   = 8'h10;
   localparam logic [7:0] PF_TKL   = 8'h0f;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_SHORT       = 4'd1,
      ST_FIXED_CLEAR = 4'd2,
      ST_RFU_SET     = 4'd3,
      ST_TOKEN_EMPTY = 4'd4,
      ST_EMPTY_LONG  = 4'd5,
      ST_EMPTY_P1P2  = 4'd6,
      ST_TKL_LARGE   = 4'd7,
      ST_LC_MISSING  = 4'd8,
      ST_EXT_MISSING = 4'd9,
      ST_TRUNCATED   = 4'd10,
      ST_TOKEN_PAST  = 4'd11
   } status_type;

   // packed low to high: body_byte first
   typedef struct packed {
      logic [16:0] body_length;
      logic [63:0] token_value;
      logic [3:0]  token_len;
      logic [1:0]  indication;
      logic        mid_flag;
      logic        reset_flag;
      logic [7:0]  msg_code;
      logic [3:0]  status;
      logic [7:0]  body_byte;
   } rsp_fields_type;

   typedef struct packed {
      logic           kind;
      rsp_fields_type fields;
   } rsp_entry_type;

endpackage

>>> src/coap_nfc_header_parser_core.sv
// ---------------------------------------------------------------------------
// CoAP-over-NFC header parser core
// Takes a PDU one byte per request; req_tlast marks the final byte. Every
// byte is decoded in the cycle it is accepted, so one request per cycle is
// taken. Bytes past header and token leave as body results (rsp_tuser = 0);
// the final byte adds a summary (rsp_tuser = 1) with status, body length and,
// if status is OK on a PDU over one byte, the decoded preface, code, token.
// Results pass a four-entry output queue that drains one per cycle while
// rsp_tready is high; a request is taken while at least two entries are free,
// and a final body byte yields both results. Discard the forwarded body when
// the summary status is nonzero. Configuration must be written through
// csr_wr_en/csr_index/csr_wr_data while the block is idle; not enforced.
// ---------------------------------------------------------------------------
module coap_nfc_header_parser_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_index,      // 0 compat_mode, 1 upstream_dir
   input  logic [0:0]   csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,      // [7:0] data_byte
   input  logic         req_tlast,      // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,      // [7:0] body_byte, [11:8] status,
                                        // [19:12] msg_code, [20] reset_flag,
                                        // [21] mid_flag, [23:22] indication,
                                        // [27:24] token_len,
                                        // [91:28] token_value,
                                        // [108:92] body_length, rest zero
   output logic         rsp_tuser       // kind: 0 body byte, 1 summary
);
   import cnhp_pkg::*;

   localparam logic CSR_COMPAT   = 1'b0;
   localparam logic CSR_UPSTREAM = 1'b1;

   logic        compat_ff, upstream_ff;
   logic [16:0] pos_ff, pos_in;
   logic [7:0]  preface_ff, preface_in;
   logic [7:0]  code_ff, code_in;
   logic        p1p2_ff, p1p2_in;
   logic [15:0] alen_ff, alen_in;
   logic        ext_ff, ext_in;
   logic [63:0] token_ff, token_in;
   logic [16:0] body_cnt_ff, body_cnt_in;

   rsp_entry_type queue_ff [4];
   logic [1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [2:0]    count_ff, count_in;

   logic        fire, pop;
   logic [7:0]  b;
   logic [3:0]  tkl;
   logic [2:0]  tstart, hdr;
   logic [4:0]  bstart;
   logic        known, tok_en, body_hit;
   logic [16:0] idx;
   logic [17:0] size;
   logic        one_byte;
   status_type  status;
   rsp_entry_type body_item, summary_item, first_item;
   logic        push0, push1;

   assign b     = req_tdata;
   assign fire  = req_tvalid && req_tready;
   assign pop   = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= 3'd2);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         compat_ff   <= 1'b0;
         upstream_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index[0])
            CSR_COMPAT:   compat_ff   <= csr_wr_data[0];
            CSR_UPSTREAM: upstream_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // header capture
   always_comb begin
      preface_in = (pos_ff == 17'd0) ? b : preface_ff;
      code_in    = (pos_ff == 17'd1) ? b : code_ff;
      p1p2_in    = p1p2_ff || ((pos_ff == 17'd2 || pos_ff == 17'd3) && b != 8'd0);
      ext_in     = ext_ff;
      alen_in    = alen_ff;
      if (compat_ff) begin
         if (pos_ff == 17'd4) begin
            ext_in  = (b == 8'd0);
            alen_in = {8'd0, b};
         end else if (pos_ff == 17'd5 && ext_ff) begin
            alen_in = {b, 8'd0};
         end else if (pos_ff == 17'd6 && ext_ff) begin
            alen_in = {alen_ff[15:8], b};
         end
      end
   end

   // token and body placement
   always_comb begin
      tkl    = preface_in[3:0] & PF_TKL[3:0];
      hdr    = ext_in ? 3'd7 : 3'd5;
      tstart = (!compat_ff || tkl <= 4'd2) ? 3'd2 : hdr;
      priority if (!compat_ff) bstart = 5'd2 + {1'b0, tkl};
      else if (tkl <= 4'd2)    bstart = {2'b00, hdr};
      else                     bstart = {2'b00, hdr} + {1'b0, tkl};
      known = !compat_ff || (pos_ff >= 17'd5);
      idx   = pos_ff - {14'd0, tstart};
      tok_en = (pos_ff >= 17'd2) && (known || (compat_ff && tkl <= 4'd2))
               && (pos_ff >= {14'd0, tstart}) && (idx < {13'd0, tkl})
               && (idx < 17'(MAX_TOKEN_BYTES));
      token_in = tok_en ? (token_ff | ({56'd0, b} << {idx[2:0], 3'b000})) : token_ff;
      body_hit = known && (pos_ff >= 17'd2) && (pos_ff >= {12'd0, bstart});
      body_cnt_in = (body_hit && body_cnt_ff != POS_SAT) ? body_cnt_ff + 17'd1
                                                         : body_cnt_ff;
      pos_in = (pos_ff != POS_SAT) ? pos_ff + 17'd1 : pos_ff;
   end

   // PDU checks for the final byte, in priority order
   always_comb begin
      size     = {1'b0, pos_ff} + 18'd1;
      status   = ST_OK;
      one_byte = 1'b0;
      priority if (size < (compat_ff ? 18'd4 : 18'd1))   status = ST_SHORT;
      else if ((preface_in & PF_FIXED) == 8'd0)          status = ST_FIXED_CLEAR;
      else if (!upstream_ff && (preface_in & PF_RFU) != 8'd0) status = ST_RFU_SET;
      else if (tkl != 4'd0 && (size == 18'd1 || code_in == 8'd0))
         status = ST_TOKEN_EMPTY;
      else if (!compat_ff && size == 18'd1)              one_byte = 1'b1;
      else if (code_in == 8'd0 && compat_ff && size > 18'd4) status = ST_EMPTY_LONG;
      else if (code_in == 8'd0 && compat_ff && p1p2_in)  status = ST_EMPTY_P1P2;
      else if (code_in == 8'd0 && !compat_ff && size > 18'd2) status = ST_EMPTY_LONG;
      else if (32'(tkl) > MAX_TOKEN_BYTES)               status = ST_TKL_LARGE;
      else if (!compat_ff) begin
         status = (18'd2 + {14'd0, tkl} > size) ? ST_TOKEN_PAST : ST_OK;
      end
      else if (tkl > 4'd2 && size < 18'd5)               status = ST_LC_MISSING;
      else if (size < 18'd5)                             status = ST_OK;
      else if (ext_in && size < 18'd7)                   status = ST_EXT_MISSING;
      else if (size < {2'b00, alen_in} + {15'd0, hdr})   status = ST_TRUNCATED;
      else if ({15'd0, hdr} + ((tkl > 4'd2) ? {14'd0, tkl} : 18'd0) > size)
         status = ST_TOKEN_PAST;
      else                                               status = ST_OK;
   end

   // result records
   always_comb begin
      body_item = '0;
      body_item.fields.body_byte = b;
      summary_item = '0;
      summary_item.kind = 1'b1;
      summary_item.fields.status = status;
      if (status == ST_OK && !one_byte) begin
         summary_item.fields.msg_code    = code_in;
         summary_item.fields.reset_flag  = (preface_in & PF_RESET) != 8'd0;
         summary_item.fields.mid_flag    = !upstream_ff && ((preface_in & PF_MID) != 8'd0);
         summary_item.fields.indication  = upstream_ff ? preface_in[5:4] : 2'd0;
         summary_item.fields.token_len   = tkl;
         summary_item.fields.token_value = token_in;
      end
      summary_item.fields.body_length = body_cnt_in;
      first_item = body_hit ? body_item : summary_item;
      push0 = fire && (body_hit || req_tlast);
      push1 = fire && body_hit && req_tlast;
      count_in = count_ff + {2'b00, push0} + {2'b00, push1} - {2'b00, pop};
   end

   // per-PDU state: advance on each request, clear after the final byte
   always_ff @(posedge clock) begin
      if (reset || (fire && req_tlast)) begin
         pos_ff      <= '0;
         preface_ff  <= '0;
         code_ff     <= '0;
         p1p2_ff     <= 1'b0;
         alen_ff     <= '0;
         ext_ff      <= 1'b0;
         token_ff    <= '0;
         body_cnt_ff <= '0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         preface_ff  <= preface_in;
         code_ff     <= code_in;
         p1p2_ff     <= p1p2_in;
         alen_ff     <= alen_in;
         ext_ff      <= ext_in;
         token_ff    <= token_in;
         body_cnt_ff <= body_cnt_in;
      end
   end

   // output queue
   always_ff @(posedge clock) begin
      if (push0) queue_ff[wr_ptr_ff] <= first_item;
      if (push1) queue_ff[wr_ptr_ff + 2'd1] <= summary_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + {1'b0, push0} + {1'b0, push1};
         if (pop) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_in;
      end
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tdata  = {3'b000, queue_ff[rd_ptr_ff].fields};

endmodule

>>> src/cnhp_checker.sv
// ---------------------------------------------------------------------------
// CoAP-over-NFC header parser port checker
// Watches the top-level stream ports and flags malformed results.
// ---------------------------------------------------------------------------
`include "coap_nfc_header_parser_core_macros.svh"

module cnhp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic         rsp_tuser
);
   import cnhp_pkg::*;

   // a stalled result stays offered
   `CNHP_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // a final byte always leaves a summary waiting
   `CNHP_ASSERT_NXT(a_summary_due, req_tvalid && req_tready && req_tlast, rsp_tvalid)
   // body results carry nothing but the byte
   `CNHP_ASSERT_IMP(a_body_clean, rsp_tvalid && !rsp_tuser, rsp_tdata[111:8] == '0)
   // error summaries blank the decoded header and token
   `CNHP_ASSERT_IMP(a_err_blank, rsp_tvalid && rsp_tuser && rsp_tdata[11:8] != ST_OK,
                    rsp_tdata[91:12] == '0 && rsp_tdata[11:8] <= ST_TOKEN_PAST)

endmodule

bind coap_nfc_header_parser_core cnhp_checker u_cnhp_checker (.*);
